@@ sv/assert_macros.svh @@
// Assertion helpers for the page frame replacement block.
// Each use expands to one labelled concurrent assertion clocked on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, ignored while reset is held.
`define FPFR_ASSERT_AT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Invariant on registered state; the same form, named for readability.
`define FPFR_ASSERT_ALWAYS(label, expr, msg) `FPFR_ASSERT_AT(label, expr, msg)

`endif

@@ sv/fpfr_pkg.sv @@
package fpfr_pkg;

    // Table geometry.
    localparam int FRAMES    = 128;
    localparam int PAGE_BITS = 6;
    localparam int PROC_BITS = 8;

    localparam int FRAME_W = $clog2(FRAMES);

    // Each cell of the chain owns a small group of frames.
    localparam int CELL_FRAMES = 8;
    localparam int CELL_LOW_W  = $clog2(CELL_FRAMES);
    localparam int CELL_CNT_W  = $clog2(CELL_FRAMES + 1);
    localparam int CELLS       = (FRAMES + CELL_FRAMES - 1) / CELL_FRAMES;
    localparam int CELL_IDX_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int SLOT_W      = CELL_IDX_W + CELL_LOW_W;

    // Count of frames cleared by a release, and the scan step counter.
    localparam int CNT_W  = $clog2(FRAMES + 1);
    localparam int STEP_W = $clog2(CELLS + 1);

    // Stream field widths.
    localparam int IN_PROC_W   = 8;
    localparam int IN_PAGE_W   = 6;
    localparam int S_TDATA_W   = 16;
    localparam int OUT_FRAME_W = 7;
    localparam int OUT_OWNER_W = 8;
    localparam int OUT_PAGE_W  = 6;
    localparam int OUT_FREE_W  = 7;
    localparam int M_TDATA_W   = 32;
    localparam int OUT_PAD_W   = M_TDATA_W
                                 - (1 + OUT_FRAME_W + 1 + OUT_OWNER_W + OUT_PAGE_W + OUT_FREE_W);

    typedef enum logic
    {
        OP_REF     = 1'b0,
        OP_RELEASE = 1'b1
    } fpfr_op_t;

    typedef enum logic
    {
        ST_IDLE,
        ST_SCAN
    } fpfr_state_t;

    // Request held steady for the whole life of an item.
    typedef struct packed
    {
        fpfr_op_t               op;
        logic [PROC_BITS-1:0]   proc;
        logic [PAGE_BITS-1:0]   page;
    } fpfr_req_t;

    // Update command broadcast to every cell in the commit cycle.
    typedef struct packed
    {
        logic                   write_en;
        logic                   clear_en;
        logic [FRAME_W-1:0]     victim;
    } fpfr_cmd_t;

    // Partial result handed from cell to cell along the chain.
    typedef struct packed
    {
        logic                   found;
        logic [FRAME_W-1:0]     frame;
        logic [CNT_W-1:0]       cleared;
        logic                   vict_valid;
        logic [PROC_BITS-1:0]   vict_owner;
        logic [PAGE_BITS-1:0]   vict_page;
    } fpfr_acc_t;

endpackage

@@ sv/fifo_page_frame_replacement_unit.sv @@
// A request accepted in idle gives its result on m_tvalid once its partial result has walked the
// whole chain (128 frames in 16 cells) and the output register is free to take the result.
// Only one request is in flight: a new request is taken only after the last one has committed.
// Reset (rst_n, asynchronous, active low) clears every valid mark at once, sets the victim
// pointer to frame one and the free count to FRAMES minus one; no clearing pass is needed.
module fifo_page_frame_replacement_unit
    import fpfr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_W-1:0]    s_tdata,    // proc_id [7:0], page [13:8], zero [15:14]
    input  logic [0:0]              s_tuser,    // op [0]
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_W-1:0]    m_tdata     // hit [0], frame [7:1], evicted_valid [8],
                                                // evicted_owner [16:9], evicted_page [22:17],
                                                // free_frames [29:23], zero [31:30]
);

    // The frame table is spread over a row of identical cells, each owning a
    // group of frames. Every cell compares the held request against its own
    // frames in parallel and merges its findings into a partial result that it
    // registers and hands to its neighbour. Once the partial result has passed every
    // cell, the end of the chain holds the lowest matching frame, the number of frames
    // owned by the requesting process and the current contents of the victim frame.

    fpfr_state_t            state_reg;
    fpfr_state_t            state_next;
    logic [STEP_W-1:0]      step_reg;
    logic [STEP_W-1:0]      step_next;
    fpfr_req_t              req_reg;
    fpfr_req_t              req_next;
    logic [FRAME_W-1:0]     victim_reg;
    logic [FRAME_W-1:0]     victim_next;
    logic [FRAME_W-1:0]     free_reg;
    logic [FRAME_W-1:0]     free_next;
    logic                   m_tvalid_reg;
    logic                   m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg;
    logic [M_TDATA_W-1:0]   m_tdata_next;

    fpfr_cmd_t              cmd;
    fpfr_acc_t              chain [CELLS + 1];
    fpfr_acc_t              final_acc;

    logic                   res_hit;
    logic [FRAME_W-1:0]     res_frame;
    logic                   ev_valid;
    logic [PROC_BITS-1:0]   ev_owner;
    logic [PAGE_BITS-1:0]   ev_page;
    logic [CNT_W:0]         free_sum;

    // The head of the chain starts from an empty partial result.
    assign chain[0]  = '0;
    assign final_acc = chain[CELLS];

    for (genvar k = 0; k < CELLS; k++)
    begin : g_cell
        fpfr_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (CELL_IDX_W'(k)),
            .req      (req_reg),
            .cmd      (cmd),
            .acc_in   (chain[k]),
            .acc_out  (chain[k + 1])
        );
    end

    // Control: take a request in idle, wait for the chain to settle and the output
    // register to be free, then commit the update and load the output register in
    // the same cycle. The output register lets a new request in while a result still waits.
    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        req_next      = req_reg;
        victim_next   = victim_reg;
        free_next     = free_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        cmd.write_en  = 1'b0;
        cmd.clear_en  = 1'b0;
        cmd.victim    = victim_reg;
        res_hit       = 1'b0;
        res_frame     = '0;
        ev_valid      = 1'b0;
        ev_owner      = '0;
        ev_page       = '0;
        free_sum      = (CNT_W + 1)'(free_reg) + (CNT_W + 1)'(final_acc.cleared);
        s_tready      = (state_reg == ST_IDLE);

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next.op   = fpfr_op_t'(s_tuser[0]);
                    req_next.proc = PROC_BITS'(s_tdata[IN_PROC_W-1:0]);
                    req_next.page = PAGE_BITS'(s_tdata[IN_PROC_W +: IN_PAGE_W]);
                    step_next     = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (step_reg != STEP_W'(CELLS))
                begin
                    step_next = step_reg + 1'b1;
                end
                else if (!m_tvalid_reg || m_tready)
                begin
                    if (req_reg.op == OP_RELEASE)
                    begin
                        // Every frame of the process is freed; the count saturates.
                        cmd.clear_en = 1'b1;
                        if (free_sum > (CNT_W + 1)'(FRAMES - 1))
                        begin
                            free_next = FRAME_W'(FRAMES - 1);
                        end
                        else
                        begin
                            free_next = FRAME_W'(free_sum);
                        end
                    end
                    else if (final_acc.found)
                    begin
                        res_hit   = 1'b1;
                        res_frame = final_acc.frame;
                    end
                    else
                    begin
                        // Miss: the frame under the pointer takes the new mapping.
                        cmd.write_en = 1'b1;
                        res_frame    = victim_reg;
                        if (final_acc.vict_valid)
                        begin
                            ev_valid = 1'b1;
                            ev_owner = final_acc.vict_owner;
                            ev_page  = final_acc.vict_page;
                        end
                        else if (free_reg != '0)
                        begin
                            free_next = free_reg - 1'b1;
                        end
                        // Frame zero is never a victim: wrap back to frame one.
                        if (victim_reg == FRAME_W'(FRAMES - 1))
                        begin
                            victim_next = FRAME_W'(1);
                        end
                        else
                        begin
                            victim_next = victim_reg + 1'b1;
                        end
                    end
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {OUT_PAD_W'(0),
                                     OUT_FREE_W'(free_next),
                                     OUT_PAGE_W'(ev_page),
                                     OUT_OWNER_W'(ev_owner),
                                     ev_valid,
                                     OUT_FRAME_W'(res_frame),
                                     res_hit};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            victim_reg   <= FRAME_W'(1);
            free_reg     <= FRAME_W'(FRAMES - 1);
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            victim_reg   <= victim_next;
            free_reg     <= free_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks on the bookkeeping and the commit timing.
`include "assert_macros.svh"

    `FPFR_ASSERT_ALWAYS(a_free_bound, free_reg <= FRAME_W'(FRAMES - 1), "free count out of range")
    `FPFR_ASSERT_ALWAYS(a_victim_range, (victim_reg != '0) && (victim_reg <= FRAME_W'(FRAMES - 1)), "victim pointer out of range")
    `FPFR_ASSERT_AT(a_commit_settled, (cmd.write_en || cmd.clear_en) |-> (step_reg == STEP_W'(CELLS)), "table updated before the chain settled")
    `FPFR_ASSERT_AT(a_hit_no_evict, (m_tvalid && m_tdata[0]) |-> !m_tdata[8], "hit reported with an eviction")

endmodule

@@ sv/fpfr_cell.sv @@
module fpfr_cell
    import fpfr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [CELL_IDX_W-1:0]   cell_idx,
    input  fpfr_req_t               req,
    input  fpfr_cmd_t               cmd,
    input  fpfr_acc_t               acc_in,
    output fpfr_acc_t               acc_out
);

    logic [PROC_BITS-1:0]   owner_reg [CELL_FRAMES];
    logic [PAGE_BITS-1:0]   page_reg  [CELL_FRAMES];
    logic [CELL_FRAMES-1:0] valid_reg;
    logic [CELL_FRAMES-1:0] valid_next;
    fpfr_acc_t              acc_reg;
    fpfr_acc_t              acc_next;

    logic [SLOT_W-1:0]      slot [CELL_FRAMES];
    logic [CELL_FRAMES-1:0] present;
    logic [CELL_FRAMES-1:0] owned;
    logic [CELL_FRAMES-1:0] match;
    logic [CELL_FRAMES-1:0] is_victim;

    logic                   loc_found;
    logic [FRAME_W-1:0]     loc_frame;
    logic [CELL_CNT_W-1:0]  loc_count;
    logic                   loc_has_victim;
    logic                   loc_vict_valid;
    logic [PROC_BITS-1:0]   loc_vict_owner;
    logic [PAGE_BITS-1:0]   loc_vict_page;

    // Compare the held request against every frame of this cell at once.
    always_comb
    begin
        for (int j = 0; j < CELL_FRAMES; j++)
        begin
            slot[j]      = {cell_idx, CELL_LOW_W'(j)};
            present[j]   = ({1'b0, slot[j]} < (SLOT_W + 1)'(FRAMES));
            owned[j]     = present[j] && valid_reg[j] && (owner_reg[j] == req.proc);
            match[j]     = owned[j] && (page_reg[j] == req.page);
            is_victim[j] = present[j] && (slot[j] == SLOT_W'(cmd.victim));
        end
    end

    always_comb
    begin
        loc_found      = 1'b0;
        loc_frame      = '0;
        loc_count      = '0;
        loc_has_victim = 1'b0;
        loc_vict_valid = 1'b0;
        loc_vict_owner = '0;
        loc_vict_page  = '0;
        // Walk downwards so that the lowest matching frame wins.
        for (int j = CELL_FRAMES - 1; j >= 0; j--)
        begin
            if (match[j])
            begin
                loc_found = 1'b1;
                loc_frame = FRAME_W'(slot[j]);
            end
        end
        for (int j = 0; j < CELL_FRAMES; j++)
        begin
            loc_count = loc_count + CELL_CNT_W'(owned[j]);
            if (is_victim[j])
            begin
                loc_has_victim = 1'b1;
                loc_vict_valid = valid_reg[j];
                loc_vict_owner = owner_reg[j];
                loc_vict_page  = page_reg[j];
            end
        end
    end

    // Merge with what the lower-numbered cells have found.
    always_comb
    begin
        acc_next         = acc_in;
        acc_next.cleared = acc_in.cleared + CNT_W'(loc_count);
        if (!acc_in.found)
        begin
            acc_next.found = loc_found;
            acc_next.frame = loc_frame;
        end
        if (loc_has_victim)
        begin
            acc_next.vict_valid = loc_vict_valid;
            acc_next.vict_owner = loc_vict_owner;
            acc_next.vict_page  = loc_vict_page;
        end
    end

    always_comb
    begin
        for (int j = 0; j < CELL_FRAMES; j++)
        begin
            valid_next[j] = valid_reg[j];
            if (cmd.write_en && is_victim[j])
            begin
                valid_next[j] = 1'b1;
            end
            else if (cmd.clear_en && owned[j])
            begin
                valid_next[j] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < CELL_FRAMES; j++)
        begin
            if (cmd.write_en && is_victim[j])
            begin
                owner_reg[j] <= req.proc;
                page_reg[j]  <= req.page;
            end
        end
    end

    assign acc_out = acc_reg;

endmodule
